// ===== sv/vtts_pkg.sv =====
// ----------------------------------------------------------------------------
// vtts_pkg
// Shared sizes, codes and control bundles of the vector table search block.
// ----------------------------------------------------------------------------
package vtts_pkg;

    localparam int ROW_CAPACITY = 1024;
    localparam int DIM_MAX      = 128;
    localparam int K_MAX        = 64;

    localparam int ROW_W  = $clog2(ROW_CAPACITY);
    localparam int RCNT_W = ROW_W + 1;
    localparam int DIM_W  = $clog2(DIM_MAX);
    localparam int DCNT_W = DIM_W + 1;
    localparam int K_W    = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int KCNT_W = $clog2(K_MAX + 1);

    localparam int ELEM_W  = 16;
    localparam int ID_W    = 32;
    localparam int SCORE_W = 48;
    localparam int RANK_W  = 6;
    localparam int PROD_W  = 2 * (ELEM_W + 1);
    localparam int META_W  = ID_W + 1;
    localparam int VEC_AW  = ROW_W + DIM_W;

    localparam int CFG_W   = 8;
    localparam int CFG_AW  = 2;

    // commands
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_ERASE = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    // result status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    // metrics
    localparam logic [1:0] MODE_L2   = 2'd0;
    localparam logic [1:0] MODE_IP   = 2'd1;
    localparam logic [1:0] MODE_COS  = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    // register indexes
    localparam logic [CFG_AW-1:0] CFG_METRIC = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_TOPK   = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_DIM    = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_INSERT = 2'd3;

    localparam logic signed [SCORE_W-1:0] SCORE_ONE = 48'sh0000_0100_0000;
    localparam logic signed [SCORE_W-1:0] SCORE_TOP = 48'sh7FFF_FFFF_FFFF;

    typedef struct packed {
        logic clr;
        logic rd;
        logic qv;
    } mac_ctl_t;

    typedef struct packed {
        logic              clr;
        logic              ins;
        logic              pop;
        logic [KCNT_W-1:0] k;
    } topk_ctl_t;

endpackage

// ===== sv/vtts_ram.sv =====
// ----------------------------------------------------------------------------
// vtts_ram
// Simple dual-port synchronous RAM, one write port, registered read.
// ----------------------------------------------------------------------------
module vtts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/vtts_score.sv =====
// ----------------------------------------------------------------------------
// vtts_score
// Element multiply-accumulate: one product per cycle, then final metric.
// ----------------------------------------------------------------------------
module vtts_score
    import vtts_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  mac_ctl_t                  ctl,
    input  logic [1:0]                mode,
    input  logic signed [ELEM_W-1:0]  q_data,
    input  logic signed [ELEM_W-1:0]  e_data,
    output logic                      busy,
    output logic signed [SCORE_W-1:0] score
);

    logic                      p1_v_reg;
    logic                      p1_qv_reg;
    logic                      p2_v_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [SCORE_W-1:0] acc_reg;

    logic signed [ELEM_W-1:0]  q_eff;
    logic signed [ELEM_W:0]    q_ext;
    logic signed [ELEM_W:0]    e_ext;
    logic signed [ELEM_W:0]    diff;
    logic signed [ELEM_W:0]    op_a;
    logic signed [ELEM_W:0]    op_b;
    logic signed [PROD_W-1:0]  prod_c;

    // staging entries never written read as zero
    assign q_eff  = p1_qv_reg ? q_data : '0;
    assign q_ext  = {q_eff[ELEM_W-1], q_eff};
    assign e_ext  = {e_data[ELEM_W-1], e_data};
    assign diff   = q_ext - e_ext;
    assign op_a   = (mode == MODE_L2) ? diff : q_ext;
    assign op_b   = (mode == MODE_L2) ? diff : e_ext;
    assign prod_c = op_a * op_b;
    assign busy   = p1_v_reg | p2_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg  <= 1'b0;
            p1_qv_reg <= 1'b0;
            p2_v_reg  <= 1'b0;
        end
        else
        begin
            p1_v_reg  <= ctl.rd;
            p1_qv_reg <= ctl.qv;
            p2_v_reg  <= p1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_c;
        if (ctl.clr)
        begin
            acc_reg <= '0;
        end
        else if (p2_v_reg)
        begin
            acc_reg <= acc_reg + SCORE_W'(prod_reg);
        end
    end

    always_comb
    begin
        unique case (mode)
            MODE_L2:  score = acc_reg;
            MODE_IP:  score = -acc_reg;
            MODE_COS: score = SCORE_ONE - acc_reg;
            default:  score = SCORE_TOP;
        endcase
    end

endmodule

// ===== sv/vtts_topk.sv =====
// ----------------------------------------------------------------------------
// vtts_topk
// Sorted insertion list of the best scores, popped from the head.
// ----------------------------------------------------------------------------
module vtts_topk
    import vtts_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  topk_ctl_t                 ctl,
    input  logic signed [SCORE_W-1:0] score_in,
    input  logic [ID_W-1:0]           id_in,
    output logic signed [SCORE_W-1:0] head_score,
    output logic [ID_W-1:0]           head_id,
    output logic [KCNT_W-1:0]         count
);

    logic signed [SCORE_W-1:0] cell_score [K_MAX];
    logic [ID_W-1:0]           cell_id    [K_MAX];
    logic signed [SCORE_W-1:0] nxt_score  [K_MAX];
    logic [ID_W-1:0]           nxt_id     [K_MAX];
    logic [KCNT_W-1:0]         n_reg;
    logic [K_MAX-1:0]          le;
    logic [K_MAX-1:0]          take_new;
    logic [K_W-1:0]            kidx;
    logic                      ins_go;

    assign kidx   = K_W'(ctl.k - 1'b1);
    assign ins_go = ctl.ins && !le[kidx];

    for (genvar j = 0; j < K_MAX; j++)
    begin : g_cell
        logic signed [SCORE_W-1:0] up_score;
        logic [ID_W-1:0]           up_id;
        logic signed [SCORE_W-1:0] dn_score;
        logic [ID_W-1:0]           dn_id;

        // cells holding a score not above the new one stay put
        assign le[j] = (KCNT_W'(j) < n_reg) && (cell_score[j] <= score_in);

        if (j == 0)
        begin : g_head
            assign take_new[j] = !le[j];
            assign dn_score    = cell_score[j];
            assign dn_id       = cell_id[j];
        end
        else
        begin : g_body
            assign take_new[j] = !le[j] && le[j-1];
            assign dn_score    = cell_score[j-1];
            assign dn_id       = cell_id[j-1];
        end

        if (j == K_MAX - 1)
        begin : g_tail
            assign up_score = cell_score[j];
            assign up_id    = cell_id[j];
        end
        else
        begin : g_mid
            assign up_score = cell_score[j+1];
            assign up_id    = cell_id[j+1];
        end

        always_comb
        begin
            nxt_score[j] = cell_score[j];
            nxt_id[j]    = cell_id[j];
            if (ins_go && !le[j])
            begin
                nxt_score[j] = take_new[j] ? score_in : dn_score;
                nxt_id[j]    = take_new[j] ? id_in : dn_id;
            end
            else if (ctl.pop)
            begin
                nxt_score[j] = up_score;
                nxt_id[j]    = up_id;
            end
        end

        always_ff @(posedge clk)
        begin
            cell_score[j] <= nxt_score[j];
            cell_id[j]    <= nxt_id[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= '0;
        end
        else if (ctl.clr)
        begin
            n_reg <= '0;
        end
        else if (ins_go)
        begin
            if (n_reg < ctl.k)
            begin
                n_reg <= n_reg + 1'b1;
            end
        end
        else if (ctl.pop)
        begin
            n_reg <= n_reg - 1'b1;
        end
    end

    assign head_score = cell_score[0];
    assign head_id    = cell_id[0];
    assign count      = n_reg;

endmodule

// ===== sv/vector_table_topk_search.sv =====
// ----------------------------------------------------------------------------
// vector_table_topk_search
// Row table with brute-force best-k search over stored vectors.
// ----------------------------------------------------------------------------
// Input stream: s_axis carries one request per beat (command in tuser, id and
// element in tdata, tlast ends a vector). Element requests are taken one per
// cycle and fill the staging buffer. Results leave on m_axis, tlast on the
// final result of a request; config registers are written through cfg_we.
// Request flow:
//   element without tlast: stored in staging, no result
//   erase or load lookup: an id scan over the metadata RAM, one row per
//     cycle, ending at the first matching live row
//   load write: copies every staging entry into the row's vector RAM slots
//   query: skips erased rows; for each live row, one element product per
//     cycle through the MAC, then the row score goes into the best-k list;
//     then the ranked results are emitted from the head of the list
// While a lookup, copy or scan runs, s_axis_tready is low. A held result
// sits in the output register and new requests are still accepted; a
// request that needs to emit waits there until m_axis_tready frees it.
// Reset empties the table and the staging buffer and restores register
// defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module vector_table_topk_search
    import vtts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [47:0]       s_axis_tdata,   // doc_id, element_value
    input  logic [1:0]        s_axis_tuser,   // command
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [87:0]       m_axis_tdata,   // result_id, score, rank
    output logic [2:0]        m_axis_tuser,   // found, status
    output logic              m_axis_tlast,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FIND  = 4'd1;
    localparam logic [3:0] ST_COPY  = 4'd2;
    localparam logic [3:0] ST_RESP  = 4'd3;
    localparam logic [3:0] ST_QMETA = 4'd4;
    localparam logic [3:0] ST_QCHK  = 4'd5;
    localparam logic [3:0] ST_QELEM = 4'd6;
    localparam logic [3:0] ST_QINS  = 4'd7;
    localparam logic [3:0] ST_QOUT  = 4'd8;

    logic [3:0]                state_reg, state_next;
    logic [1:0]                metric_reg;
    logic [6:0]                topc_reg;
    logic [7:0]                dim_reg;
    logic                      ins_reg;
    logic [ID_W-1:0]           id_reg, id_next;
    logic                      is_load_reg, is_load_next;
    logic [RCNT_W-1:0]         scan_reg, scan_next;
    logic                      chk_v_reg, chk_v_next;
    logic [ROW_W-1:0]          chk_row_reg, chk_row_next;
    logic [ROW_W-1:0]          tgt_reg, tgt_next;
    logic [RCNT_W-1:0]         row_count_reg, row_count_next;
    logic [DCNT_W-1:0]         elem_idx_reg, elem_idx_next;
    logic [DIM_MAX-1:0]        stg_valid_reg, stg_valid_next;
    logic [DCNT_W-1:0]         idx_reg, idx_next;
    logic                      cp_v_reg, cp_v_next;
    logic                      cp_qv_reg, cp_qv_next;
    logic [DIM_W-1:0]          cp_addr_reg, cp_addr_next;
    logic [ID_W-1:0]           qid_reg, qid_next;
    logic [RANK_W-1:0]         rank_reg, rank_next;
    logic                      resp_found_reg, resp_found_next;
    logic [1:0]                resp_status_reg, resp_status_next;
    logic                      out_valid_reg, out_valid_next;
    logic [ID_W-1:0]           out_id_reg, out_id_next;
    logic signed [SCORE_W-1:0] out_score_reg, out_score_next;
    logic [RANK_W-1:0]         out_rank_reg, out_rank_next;
    logic                      out_found_reg, out_found_next;
    logic [1:0]                out_status_reg, out_status_next;
    logic                      out_last_reg, out_last_next;

    logic                      meta_we;
    logic [ROW_W-1:0]          meta_waddr, meta_raddr;
    logic [META_W-1:0]         meta_wdata, meta_rdata;
    logic                      vec_we;
    logic [VEC_AW-1:0]         vec_waddr, vec_raddr;
    logic [ELEM_W-1:0]         vec_wdata, vec_rdata;
    logic                      stg_we;
    logic [DIM_W-1:0]          stg_waddr, stg_raddr;
    logic [ELEM_W-1:0]         stg_wdata, stg_rdata;

    mac_ctl_t                  mac_ctl;
    topk_ctl_t                 tk_ctl;
    logic                      mac_busy;
    logic signed [SCORE_W-1:0] row_score;
    logic signed [SCORE_W-1:0] head_score;
    logic [ID_W-1:0]           head_id;
    logic [KCNT_W-1:0]         tk_count;

    logic [DCNT_W-1:0]         d_eff;
    logic [KCNT_W-1:0]         k_eff;
    logic                      in_acc;
    logic [1:0]                in_cmd;
    logic                      in_elem;
    logic                      out_free;
    logic                      hit;
    logic                      rd_go;

    assign d_eff = (dim_reg == '0) ? DCNT_W'(1) :
                   ({1'b0, dim_reg} > 9'(DIM_MAX)) ? DCNT_W'(DIM_MAX) : DCNT_W'(dim_reg);
    assign k_eff = (topc_reg == '0) ? KCNT_W'(1) :
                   ({1'b0, topc_reg} > 8'(K_MAX)) ? KCNT_W'(K_MAX) : KCNT_W'(topc_reg);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign in_cmd   = s_axis_tuser;
    assign in_elem  = (in_cmd == CMD_LOAD) || (in_cmd == CMD_QUERY);
    assign out_free = !out_valid_reg || m_axis_tready;
    assign hit      = chk_v_reg && meta_rdata[META_W-1] && (meta_rdata[ID_W-1:0] == id_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_reg <= MODE_L2;
            topc_reg   <= 7'd10;
            dim_reg    <= 8'd128;
            ins_reg    <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_METRIC: metric_reg <= cfg_wdata[1:0];
                CFG_TOPK:   topc_reg   <= cfg_wdata[6:0];
                CFG_DIM:    dim_reg    <= cfg_wdata[7:0];
                CFG_INSERT: ins_reg    <= cfg_wdata[0];
                default:    ins_reg    <= ins_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        id_next          = id_reg;
        is_load_next     = is_load_reg;
        scan_next        = scan_reg;
        chk_v_next       = 1'b0;
        chk_row_next     = chk_row_reg;
        tgt_next         = tgt_reg;
        row_count_next   = row_count_reg;
        elem_idx_next    = elem_idx_reg;
        stg_valid_next   = stg_valid_reg;
        idx_next         = idx_reg;
        cp_v_next        = 1'b0;
        cp_qv_next       = cp_qv_reg;
        cp_addr_next     = cp_addr_reg;
        qid_next         = qid_reg;
        rank_next        = rank_reg;
        resp_found_next  = resp_found_reg;
        resp_status_next = resp_status_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_id_next      = out_id_reg;
        out_score_next   = out_score_reg;
        out_rank_next    = out_rank_reg;
        out_found_next   = out_found_reg;
        out_status_next  = out_status_reg;
        out_last_next    = out_last_reg;

        meta_we    = 1'b0;
        meta_waddr = chk_row_reg;
        meta_wdata = {1'b0, id_reg};
        meta_raddr = scan_reg[ROW_W-1:0];
        vec_we     = 1'b0;
        vec_waddr  = {tgt_reg, cp_addr_reg};
        vec_wdata  = cp_qv_reg ? stg_rdata : '0;
        vec_raddr  = {scan_reg[ROW_W-1:0], idx_reg[DIM_W-1:0]};
        stg_we     = 1'b0;
        stg_waddr  = elem_idx_reg[DIM_W-1:0];
        stg_wdata  = s_axis_tdata[47:32];
        stg_raddr  = idx_reg[DIM_W-1:0];
        mac_ctl    = '0;
        tk_ctl     = '0;
        tk_ctl.k   = k_eff;
        rd_go      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    id_next = s_axis_tdata[ID_W-1:0];
                    scan_next = '0;
                    if (in_elem)
                    begin
                        if (elem_idx_reg < d_eff)
                        begin
                            stg_we = 1'b1;
                            stg_valid_next[elem_idx_reg[DIM_W-1:0]] = 1'b1;
                        end
                        if (elem_idx_reg < DCNT_W'(DIM_MAX))
                        begin
                            elem_idx_next = elem_idx_reg + 1'b1;
                        end
                        if (s_axis_tlast)
                        begin
                            if (in_cmd == CMD_LOAD)
                            begin
                                is_load_next = 1'b1;
                                state_next   = ST_FIND;
                            end
                            else
                            begin
                                rank_next  = '0;
                                tk_ctl.clr = 1'b1;
                                state_next = ST_QMETA;
                            end
                        end
                    end
                    else if (in_cmd == CMD_ERASE)
                    begin
                        is_load_next = 1'b0;
                        state_next   = ST_FIND;
                    end
                end
            end

            ST_FIND:
            begin
                // one metadata read per cycle, compared in the following cycle
                rd_go = (scan_reg < row_count_reg) && !hit;
                if (rd_go)
                begin
                    chk_v_next   = 1'b1;
                    chk_row_next = scan_reg[ROW_W-1:0];
                    scan_next    = scan_reg + 1'b1;
                end
                if (hit)
                begin
                    meta_we  = 1'b1;
                    tgt_next = chk_row_reg;
                    idx_next = '0;
                    if (is_load_reg)
                    begin
                        meta_wdata = {1'b1, id_reg};
                        state_next = ST_COPY;
                    end
                    else
                    begin
                        resp_found_next  = 1'b1;
                        resp_status_next = ST_OK;
                        state_next       = ST_RESP;
                    end
                end
                else if (!rd_go && !chk_v_reg)
                begin
                    resp_found_next = 1'b0;
                    if (!is_load_reg || !ins_reg)
                    begin
                        resp_status_next = ST_MISSING;
                        state_next       = ST_RESP;
                    end
                    else if (row_count_reg >= RCNT_W'(ROW_CAPACITY))
                    begin
                        resp_status_next = ST_FULL;
                        state_next       = ST_RESP;
                    end
                    else
                    begin
                        meta_we        = 1'b1;
                        meta_waddr     = row_count_reg[ROW_W-1:0];
                        meta_wdata     = {1'b1, id_reg};
                        tgt_next       = row_count_reg[ROW_W-1:0];
                        row_count_next = row_count_reg + 1'b1;
                        idx_next       = '0;
                        state_next     = ST_COPY;
                    end
                end
            end

            ST_COPY:
            begin
                if (idx_reg < DCNT_W'(DIM_MAX))
                begin
                    cp_v_next    = 1'b1;
                    cp_addr_next = idx_reg[DIM_W-1:0];
                    cp_qv_next   = stg_valid_reg[idx_reg[DIM_W-1:0]];
                    idx_next     = idx_reg + 1'b1;
                end
                if (cp_v_reg)
                begin
                    vec_we = 1'b1;
                end
                if ((idx_reg == DCNT_W'(DIM_MAX)) && !cp_v_reg)
                begin
                    resp_found_next  = 1'b1;
                    resp_status_next = ST_OK;
                    state_next       = ST_RESP;
                end
            end

            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_id_next     = id_reg;
                    out_score_next  = '0;
                    out_rank_next   = '0;
                    out_found_next  = resp_found_reg;
                    out_status_next = resp_status_reg;
                    out_last_next   = 1'b1;
                    if (is_load_reg)
                    begin
                        stg_valid_next = '0;
                        elem_idx_next  = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_QMETA:
            begin
                state_next = (scan_reg < row_count_reg) ? ST_QCHK : ST_QOUT;
            end

            ST_QCHK:
            begin
                if (meta_rdata[META_W-1])
                begin
                    qid_next    = meta_rdata[ID_W-1:0];
                    idx_next    = '0;
                    mac_ctl.clr = 1'b1;
                    state_next  = ST_QELEM;
                end
                else
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = ST_QMETA;
                end
            end

            ST_QELEM:
            begin
                if (idx_reg < d_eff)
                begin
                    mac_ctl.rd = 1'b1;
                    mac_ctl.qv = stg_valid_reg[idx_reg[DIM_W-1:0]];
                    idx_next   = idx_reg + 1'b1;
                end
                else if (!mac_busy)
                begin
                    state_next = ST_QINS;
                end
            end

            ST_QINS:
            begin
                tk_ctl.ins = 1'b1;
                scan_next  = scan_reg + 1'b1;
                state_next = ST_QMETA;
            end

            ST_QOUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    if (tk_count == '0)
                    begin
                        // no live row: a single empty result
                        out_id_next    = '0;
                        out_score_next = '0;
                        out_rank_next  = '0;
                        out_found_next = 1'b0;
                        out_last_next  = 1'b1;
                        stg_valid_next = '0;
                        elem_idx_next  = '0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        out_id_next    = head_id;
                        out_score_next = head_score;
                        out_rank_next  = rank_reg;
                        out_found_next = 1'b1;
                        out_last_next  = (tk_count == KCNT_W'(1));
                        tk_ctl.pop     = 1'b1;
                        rank_next      = rank_reg + 1'b1;
                        if (tk_count == KCNT_W'(1))
                        begin
                            stg_valid_next = '0;
                            elem_idx_next  = '0;
                            state_next     = ST_IDLE;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            is_load_reg     <= 1'b0;
            scan_reg        <= '0;
            chk_v_reg       <= 1'b0;
            row_count_reg   <= '0;
            elem_idx_reg    <= '0;
            stg_valid_reg   <= '0;
            idx_reg         <= '0;
            cp_v_reg        <= 1'b0;
            rank_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            is_load_reg     <= is_load_next;
            scan_reg        <= scan_next;
            chk_v_reg       <= chk_v_next;
            row_count_reg   <= row_count_next;
            elem_idx_reg    <= elem_idx_next;
            stg_valid_reg   <= stg_valid_next;
            idx_reg         <= idx_next;
            cp_v_reg        <= cp_v_next;
            rank_reg        <= rank_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg          <= id_next;
        chk_row_reg     <= chk_row_next;
        tgt_reg         <= tgt_next;
        cp_qv_reg       <= cp_qv_next;
        cp_addr_reg     <= cp_addr_next;
        qid_reg         <= qid_next;
        resp_found_reg  <= resp_found_next;
        resp_status_reg <= resp_status_next;
        out_id_reg      <= out_id_next;
        out_score_reg   <= out_score_next;
        out_rank_reg    <= out_rank_next;
        out_found_reg   <= out_found_next;
        out_status_reg  <= out_status_next;
        out_last_reg    <= out_last_next;
    end

    vtts_ram #(.WIDTH(META_W), .DEPTH(ROW_CAPACITY)) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    vtts_ram #(.WIDTH(ELEM_W), .DEPTH(ROW_CAPACITY * DIM_MAX)) u_vec_ram (
        .clk   (clk),
        .we    (vec_we),
        .waddr (vec_waddr),
        .wdata (vec_wdata),
        .raddr (vec_raddr),
        .rdata (vec_rdata)
    );

    vtts_ram #(.WIDTH(ELEM_W), .DEPTH(DIM_MAX)) u_stg_ram (
        .clk   (clk),
        .we    (stg_we),
        .waddr (stg_waddr),
        .wdata (stg_wdata),
        .raddr (stg_raddr),
        .rdata (stg_rdata)
    );

    vtts_score u_score (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .mode   (metric_reg),
        .q_data (stg_rdata),
        .e_data (vec_rdata),
        .busy   (mac_busy),
        .score  (row_score)
    );

    vtts_topk u_topk (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (tk_ctl),
        .score_in   (row_score),
        .id_in      (qid_reg),
        .head_score (head_score),
        .head_id    (head_id),
        .count      (tk_count)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_rank_reg, out_score_reg, out_id_reg};
    assign m_axis_tuser  = {out_status_reg, out_found_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== sv/vtts_chk.sv =====
// ----------------------------------------------------------------------------
// vtts_chk
// Port-level checks on the result stream of the vector table search block.
// ----------------------------------------------------------------------------
module vtts_chk
    import vtts_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // error status results stand alone and name no row
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[2:1] != ST_OK) |->
            m_axis_tlast && !m_axis_tuser[0])
        else $error("error result not single");

    // a result naming no row has zero score and rank and ends its request
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tlast && (m_axis_tdata[ID_W +: SCORE_W + RANK_W] == '0))
        else $error("empty result carries score or rank");

    // a non-final request other than an erase produces no result
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tlast
            && (s_axis_tuser != CMD_ERASE) |=> !$rose(m_axis_tvalid))
        else $error("result after non-final element");

endmodule

bind vector_table_topk_search vtts_chk u_vtts_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
